[design/tfp_pkg.sv]
// Shared types and constants for the telemetry frame parser.
package tfp_pkg;

  // Field widths of the stream and of the frame counters.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 17;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ShiftW = 24;
  localparam int unsigned ValueW = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SensW  = 3;

  // Smallest frame that can carry a reading, and the saturating count limit.
  localparam logic [CountW-1:0] MinFrame = CountW'(7);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Result kinds.
  localparam logic [KindW-1:0] KIND_IDENT   = 2'd0;
  localparam logic [KindW-1:0] KIND_READING = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic ERR_TOO_SHORT = 1'b0;
  localparam logic ERR_TRUNCATED = 1'b1;

  // Sensor classes.
  localparam logic [SensW-1:0] SENS_GENERIC = 3'd0;
  localparam logic [7:0]       CODE_FIRST   = 8'd1;
  localparam logic [7:0]       CODE_LAST    = 8'd4;

  // Position within a frame, one-hot.
  typedef enum logic [5:0] {
    PH_LEN_HI = 6'b000001,
    PH_LEN_LO = 6'b000010,
    PH_IDENT  = 6'b000100,
    PH_CODE   = 6'b001000,
    PH_VALUE  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  // Per-frame parser state.
  typedef struct packed {
    phase_t              phase;
    logic [CountW-1:0]   byte_count;
    logic [LenW-1:0]     ident_length;
    logic [ByteW-1:0]    code_hold;
    logic [ShiftW-1:0]   value_shift;
  } frame_state_t;

  // One result item, with a flag saying whether the input item produced one.
  typedef struct packed {
    logic               valid;
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   id_char;
    logic [SensW-1:0]   sensor_kind;
    logic [ValueW-1:0]  value_bits;
    logic               error_code;
  } result_t;

  // Frame state after reset and after every frame end.
  localparam frame_state_t StateClear = '{
    phase:        PH_LEN_HI,
    byte_count:   '0,
    ident_length: '0,
    code_hold:    '0,
    value_shift:  '0
  };

endpackage

[design/tfp_decode.sv]
// Combinational per-byte step of the frame parser: next state and result.
module tfp_decode (
  input  tfp_pkg::frame_state_t      state_i,
  input  logic [tfp_pkg::ByteW-1:0]  byte_i,
  input  logic                       last_i,
  output tfp_pkg::frame_state_t      state_o,
  output tfp_pkg::result_t           result_o
);
  import tfp_pkg::*;

  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] reading_at;
  logic [CountW-1:0] ident_end;
  logic [LenW-1:0]   len_full;
  frame_state_t      step;
  result_t           res;

  // Saturating byte count, including this byte.
  assign count_inc  = (state_i.byte_count != CountMax) ? state_i.byte_count + 1'b1
                                                       : state_i.byte_count;
  assign reading_at = {1'b0, state_i.ident_length} + MinFrame;
  assign ident_end  = {1'b0, state_i.ident_length} + CountW'(2);
  assign len_full   = {state_i.ident_length[LenW-1:ByteW], byte_i};

  // Field update for the current position within the frame.
  always_comb begin
    step            = state_i;
    step.byte_count = count_inc;
    res             = '0;
    case (state_i.phase)
      PH_LEN_HI: begin
        step.ident_length = {byte_i, {ByteW{1'b0}}};
        step.phase        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        step.ident_length = len_full;
        step.phase        = (len_full == '0) ? PH_CODE : PH_IDENT;
      end
      PH_IDENT: begin
        res.valid   = 1'b1;
        res.kind    = KIND_IDENT;
        res.id_char = byte_i;
        if (count_inc >= ident_end) begin
          step.phase = PH_CODE;
        end
      end
      PH_CODE: begin
        step.code_hold = byte_i;
        step.phase     = PH_VALUE;
      end
      PH_VALUE: begin
        if (count_inc >= reading_at) begin
          res.valid      = 1'b1;
          res.kind       = KIND_READING;
          res.value_bits = {state_i.value_shift, byte_i};
          res.sensor_kind = (state_i.code_hold inside {[CODE_FIRST:CODE_LAST]})
                          ? state_i.code_hold[SensW-1:0] : SENS_GENERIC;
          step.phase     = PH_DONE;
        end else begin
          step.value_shift = {state_i.value_shift[ShiftW-ByteW-1:0], byte_i};
        end
      end
      default: begin
        // Trailing bytes after the reading change nothing.
      end
    endcase

    // A frame end before the reading replaces any result with an error.
    if (last_i) begin
      if (step.phase != PH_DONE) begin
        res            = '0;
        res.valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = (count_inc < MinFrame) ? ERR_TOO_SHORT : ERR_TRUNCATED;
      end
      step = StateClear;
    end
  end

  assign state_o  = step;
  assign result_o = res;

endmodule

[design/telemetry_frame_parser.sv]
// Top level of the telemetry frame parser: state and result registers around the byte step.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     in_byte, in_frame_end
//   out_     output     out_valid / out_stall   out_kind, out_id_char, out_sensor_kind,
//                                               out_value_bits, out_error_code
//
// One byte is taken every cycle while in_stall is low; its result, if any, appears on the next cycle.
// The whole step is one pass of the decoder between the frame state and the result register.
// Reset (rst_n low, synchronous) clears the frame state and empties the result register.
// A waiting result holds the input back only while out_stall is high; otherwise a new byte
// is taken in the same cycle that the previous result leaves.
module telemetry_frame_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tfp_pkg::ByteW-1:0]    in_byte,
  input  logic                         in_frame_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tfp_pkg::KindW-1:0]    out_kind,
  output logic [tfp_pkg::ByteW-1:0]    out_id_char,
  output logic [tfp_pkg::SensW-1:0]    out_sensor_kind,
  output logic [tfp_pkg::ValueW-1:0]   out_value_bits,
  output logic                         out_error_code
);
  import tfp_pkg::*;

  frame_state_t state_r;
  frame_state_t state_nxt;
  result_t      step_res;
  result_t      res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         accept;

  // The input is held back only by a result that cannot leave this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  tfp_decode u_decode (
    .state_i  (state_r),
    .byte_i   (in_byte),
    .last_i   (in_frame_end),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  // Frame state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateClear;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: loaded by an accepted item, emptied when taken.
  assign out_valid_nxt = accept ? step_res.valid : (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_res.valid) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_id_char     = res_r.id_char;
  assign out_sensor_kind = res_r.sensor_kind;
  assign out_value_bits  = res_r.value_bits;
  assign out_error_code  = res_r.error_code;

`ifndef SYNTH
  // A frame end always leaves the parser at the start of a fresh frame.
  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_frame_end |=> state_r.phase == PH_LEN_HI && state_r.byte_count == '0)
    else $error("frame state not cleared after frame end");

  // Identifier echoes come only from bytes taken in the identifier phase.
  a_echo_from_ident: assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r.phase != PH_IDENT |=> !(out_valid && out_kind == KIND_IDENT))
    else $error("identifier echo outside the identifier phase");

  // While identifier bytes are expected, the count stays inside the identifier field.
  a_ident_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDENT |-> state_r.ident_length != '0 &&
      state_r.byte_count >= CountW'(2) &&
      state_r.byte_count < {1'b0, state_r.ident_length} + CountW'(2))
    else $error("identifier phase with count outside the identifier field");

  // A reading comes only from a byte taken in the value phase.
  a_reading_from_value: assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r.phase != PH_VALUE |=> !(out_valid && out_kind == KIND_READING))
    else $error("reading produced outside the value phase");
`endif

endmodule

[dv/telemetry_frame_parser_test.sv]
// Self-checking testbench for the telemetry frame parser: random and directed frames.
module telemetry_frame_parser_test;
  import tfp_pkg::*;

  // A run of this many cycles with no item moving on either channel ends the run.
  localparam int unsigned QuietLimit = 2000;
  // Length and spacing of the long receiver hold-offs.
  localparam int unsigned HoldLength = 50;
  localparam int unsigned HoldPeriod = 600;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } stream_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    in_byte = '0;
  logic                in_frame_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KindW-1:0]    out_kind;
  logic [ByteW-1:0]    out_id_char;
  logic [SensW-1:0]    out_sensor_kind;
  logic [ValueW-1:0]   out_value_bits;
  logic                out_error_code;

  // Bytes waiting to be offered, and decoded results waiting to come out.
  stream_byte_t byte_queue[$];
  result_t      due_results[$];

  // Idle rates in percent and the switch for the long hold-offs.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        long_holds_on = 1'b0;

  // Own copy of the frame state, advanced once per accepted byte.
  phase_t            fp_phase = PH_LEN_HI;
  logic [CountW-1:0] fp_count = '0;
  logic [LenW-1:0]   fp_len = '0;
  logic [ByteW-1:0]  fp_code = '0;
  logic [ShiftW-1:0] fp_shift = '0;

  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned frames_taken = 0;
  int unsigned echoes_seen = 0;
  int unsigned readings_seen = 0;
  int unsigned frame_errors_seen = 0;
  int unsigned long_holds = 0;
  int unsigned hold_left = 0;
  int unsigned stall_clock = 0;
  int unsigned quiet_cycles = 0;
  result_t     taken_result;
  result_t     want;

  telemetry_frame_parser u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_id_char     (out_id_char),
    .out_sensor_kind (out_sensor_kind),
    .out_value_bits  (out_value_bits),
    .out_error_code  (out_error_code)
  );

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the frame state by one byte and return the result it causes, if any.
  function automatic result_t parse_byte(input logic [ByteW-1:0] b, input logic last);
    result_t     r;
    logic [31:0] reading_pos;
    r = '0;
    if (fp_count != CountMax) fp_count = fp_count + 1'b1;
    reading_pos = 32'(fp_len) + 32'(MinFrame);
    case (fp_phase)
      PH_LEN_HI: begin
        fp_len = {b, 8'h00};
        fp_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fp_len = {fp_len[15:8], b};
        fp_phase = (fp_len == '0) ? PH_CODE : PH_IDENT;
      end
      PH_IDENT: begin
        r.valid = 1'b1;
        r.kind = KIND_IDENT;
        r.id_char = b;
        if (32'(fp_count) >= 32'(fp_len) + 32'd2) fp_phase = PH_CODE;
      end
      PH_CODE: begin
        fp_code = b;
        fp_phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (32'(fp_count) >= reading_pos) begin
          r.valid = 1'b1;
          r.kind = KIND_READING;
          r.sensor_kind = (fp_code >= CODE_FIRST && fp_code <= CODE_LAST) ? fp_code[2:0]
                                                                           : SENS_GENERIC;
          r.value_bits = {fp_shift, b};
          fp_phase = PH_DONE;
        end else begin
          fp_shift = {fp_shift[15:0], b};
        end
      end
      default: ;
    endcase
    // A frame that ends before its reading replaces any echo with an error.
    if (last) begin
      if (fp_phase != PH_DONE) begin
        r = '0;
        r.valid = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = (fp_count < MinFrame) ? ERR_TOO_SHORT : ERR_TRUNCATED;
      end
      fp_phase = PH_LEN_HI;
      fp_count = '0;
      fp_len = '0;
      fp_code = '0;
      fp_shift = '0;
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] expected_val,
                               input logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, expected_val,
               actual_val);
      errors++;
    end
  endtask

  // Driver: offer the head of the byte queue, hold it while stalled, predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_result = parse_byte(in_byte, in_frame_end);
        if (taken_result.valid) due_results.insert(due_results.size(), taken_result);
        void'(byte_queue.pop_front());
        bytes_taken++;
        if (in_frame_end) frames_taken++;
      end
      if (in_valid && in_stall) begin
        // A stalled item stays on the bus unchanged.
      end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= byte_queue[0].data;
        in_frame_end <= byte_queue[0].last;
      end else begin
        in_valid <= 1'b0;
        in_byte <= 8'($urandom);
        in_frame_end <= 1'($urandom);
      end
    end
  end

  // Receiver stall: random idling plus periodic long hold-offs counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_clock++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_holds_on && stall_clock % HoldPeriod == HoldPeriod / 2) begin
        hold_left = HoldLength - 1;
        long_holds++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_kind == KIND_IDENT) echoes_seen++;
      else if (out_kind == KIND_READING) readings_seen++;
      else frame_errors_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, out_kind);
        errors++;
      end else begin
        want = due_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(out_kind));
        compare_field("id_char", 32'(want.id_char), 32'(out_id_char));
        compare_field("sensor_kind", 32'(want.sensor_kind), 32'(out_sensor_kind));
        compare_field("value_bits", want.value_bits, out_value_bits);
        compare_field("error_code", 32'(want.error_code), 32'(out_error_code));
      end
    end
  end

  // Watchdog on cycles in which no item moves.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Queue one frame; a non-zero cut ends it early on that byte.
  task automatic send_frame(input logic [15:0] len, input logic [7:0] code,
                            input logic [31:0] value, input int unsigned trailing,
                            input int unsigned cut);
    int unsigned  full;
    int unsigned  n;
    int unsigned  k;
    stream_byte_t item;
    full = 7 + len + trailing;
    n = (cut != 0) ? cut : full;
    for (int unsigned pos = 0; pos < n; pos++) begin
      if (pos == 0) item.data = len[15:8];
      else if (pos == 1) item.data = len[7:0];
      else if (pos < 2 + len) item.data = 8'($urandom);
      else if (pos == 2 + len) item.data = code;
      else if (pos < 7 + len) begin
        k = pos - (3 + len);
        item.data = value[31 - 8 * k -: 8];
      end else item.data = 8'($urandom);
      item.last = (pos == n - 1);
      byte_queue.insert(byte_queue.size(), item);
    end
  endtask

  // Mostly well-formed frames with random content, some cut short, some raw noise.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned  start;
    int unsigned  pick;
    logic [15:0]  len;
    logic [7:0]   code;
    int unsigned  cut_max;
    stream_byte_t item;
    start = byte_queue.size();
    while (byte_queue.size() - start < n_bytes) begin
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6));
      code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      if (pick < 65) begin
        send_frame(len, code, $urandom,
                   ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0, 0);
      end else if (pick < 87) begin
        if ($urandom_range(3) == 0) len = 16'($urandom);
        cut_max = 6 + len;
        if (cut_max > 24) cut_max = 24;
        send_frame(len, code, $urandom, 0, $urandom_range(1, cut_max));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          item.data = 8'($urandom);
          item.last = ($urandom_range(3) == 0);
          byte_queue.insert(byte_queue.size(), item);
        end
        byte_queue[$].last = ($urandom_range(1) == 0) ? byte_queue[$].last : 1'b1;
      end
    end
  endtask

  task automatic wait_drained;
    while (byte_queue.size() != 0 || due_results.size() != 0) @(negedge clk);
  endtask

  // Stimulus sequence, reset and end of run.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames: zero-length identifier with the reading on the last byte, extreme
    // values with a trailing byte, a one-byte frame, an error on an identifier byte, and a
    // frame cut off in its value.
    send_frame(16'd0, 8'd1, 32'h0000_0000, 0, 0);
    send_frame(16'd1, 8'd4, 32'hFFFF_FFFF, 1, 0);
    send_frame(16'hFFFF, 8'd0, 32'h0, 0, 1);
    send_frame(16'd2, 8'd2, 32'h0, 0, 3);
    send_frame(16'd1, 8'd3, 32'h1234_5678, 0, 7);
    wait_drained();

    // Sender idles lightly, receiver heavily, with long hold-offs.
    send_idle_pct = 24;
    recv_idle_pct = 61;
    long_holds_on = 1'b1;
    random_traffic(600);
    wait_drained();

    // The other way round.
    send_idle_pct = 61;
    recv_idle_pct = 24;
    random_traffic(600);
    wait_drained();

    // Full rate on both sides to finish.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_holds_on = 1'b0;
    random_traffic(220);
    wait_drained();

    repeat (16) @(negedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
      errors++;
    end
    $display("Run covered %0d bytes in %0d frames, several idle patterns, %0d long holds.",
             bytes_taken, frames_taken, long_holds);
    $display("Results: %0d identifier echoes, %0d readings, %0d frame errors, %0d mismatches.",
             echoes_seen, readings_seen, frame_errors_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
